@@ src/interval_set_table_unit_defines.svh @@
// Assertion macros shared by the interval set table checkers.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef INTERVAL_SET_TABLE_UNIT_DEFINES_SVH
`define INTERVAL_SET_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define IST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval set table assertion failed");

// next-cycle implication
`define IST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval set table assertion failed");

`endif

@@ src/ist_pkg.sv @@
// Types and constants for the interval set table.
// No dependencies.
`default_nettype none

package ist_pkg;

  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_MERGE  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // decisions of one walk step
  typedef struct packed {
    logic emit;
    logic advance;
    logic set_inserted;
    logic acc_upd;
    logic split_next;
    logic hit;
    logic finish;
  } step_ctl_t;

endpackage

`default_nettype wire

@@ src/ist_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ist_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/ist_step.sv @@
// One step of the table walk: compares the current entry with the range
// and the running interval, and decides what to write. Uses ist_pkg.
`default_nettype none

module ist_step
  import ist_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire cmd_t                  cmd,
  input  wire logic [VALUE_BITS-1:0] range_lo,
  input  wire logic [VALUE_BITS-1:0] range_hi,
  input  wire logic [VALUE_BITS-1:0] ent_lo,
  input  wire logic [VALUE_BITS-1:0] ent_hi,
  input  wire logic                  ent_valid,
  input  wire logic                  inserted,
  input  wire logic                  split,
  input  wire logic [VALUE_BITS-1:0] acc_lo,
  input  wire logic [VALUE_BITS-1:0] acc_hi,
  input  wire logic                  acc_valid,
  output step_ctl_t                  ctl,
  output logic      [VALUE_BITS-1:0] emit_lo,
  output logic      [VALUE_BITS-1:0] emit_hi,
  output logic      [VALUE_BITS-1:0] acc_lo_new,
  output logic      [VALUE_BITS-1:0] acc_hi_new
);

  logic                  use_new;
  logic [VALUE_BITS-1:0] elem_lo;
  logic [VALUE_BITS-1:0] elem_hi;
  logic [VALUE_BITS:0]   acc_hi_inc;
  logic                  gap;
  logic                  left;
  logic                  right;

  always_comb begin
    use_new    = !inserted && (!ent_valid || (range_lo <= ent_lo));
    elem_lo    = use_new ? range_lo : ent_lo;
    elem_hi    = use_new ? range_hi : ent_hi;
    acc_hi_inc = {1'b0, acc_hi} + {{VALUE_BITS{1'b0}}, 1'b1};
    gap        = {1'b0, elem_lo} > acc_hi_inc;
    left       = ent_lo < range_lo;
    right      = ent_hi > range_hi;

    ctl        = '0;
    emit_lo    = acc_lo;
    emit_hi    = acc_hi;
    acc_lo_new = acc_lo;
    acc_hi_new = acc_hi;

    unique case (cmd)
      CMD_MERGE: begin
        // sorted stream of entries with the range slotted in, fused on the fly
        if (use_new || ent_valid) begin
          ctl.advance      = !use_new;
          ctl.set_inserted = use_new;
          ctl.acc_upd      = 1'b1;
          if (!acc_valid) begin
            acc_lo_new = elem_lo;
            acc_hi_new = elem_hi;
          end else if (gap) begin
            ctl.emit   = 1'b1;
            acc_lo_new = elem_lo;
            acc_hi_new = elem_hi;
          end else if (elem_hi > acc_hi) begin
            acc_hi_new = elem_hi;
          end
        end else begin
          ctl.emit   = acc_valid;
          ctl.finish = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!ent_valid) begin
          ctl.finish = 1'b1;
        end else if (split) begin
          ctl.emit    = 1'b1;
          ctl.advance = 1'b1;
          emit_lo     = range_hi + 1'b1;
          emit_hi     = ent_hi;
        end else if (left && right) begin
          // split: left piece now, right piece on the next cycle
          ctl.emit       = 1'b1;
          ctl.split_next = 1'b1;
          emit_lo        = ent_lo;
          emit_hi        = range_lo - 1'b1;
        end else if (left) begin
          ctl.emit    = 1'b1;
          ctl.advance = 1'b1;
          emit_lo     = ent_lo;
          emit_hi     = (ent_hi < range_lo) ? ent_hi : range_lo - 1'b1;
        end else if (right) begin
          ctl.emit    = 1'b1;
          ctl.advance = 1'b1;
          emit_lo     = (ent_lo > range_hi) ? ent_lo : range_hi + 1'b1;
          emit_hi     = ent_hi;
        end else begin
          ctl.advance = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (!ent_valid) begin
          ctl.finish = 1'b1;
        end else begin
          ctl.advance = 1'b1;
          ctl.hit     = (ent_lo <= range_lo) && (range_hi <= ent_hi);
        end
      end
      default: begin
        ctl.finish = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/interval_set_table_unit.sv @@
// Top level of the interval set table: sequencer, table RAM and walk unit.
// Depends on ist_pkg, ist_ram and ist_step.
//
// Usage. A command word (command, range_low, range_high) is taken at a rising
// edge with start high and busy low. Merge fuses the range into the table,
// remove cuts it out, query asks whether one stored interval holds it.
// Exactly one result word (covered, table_full, interval_count) follows,
// shown for one cycle with done high; the receiver must take it then, as
// it cannot stall the block.
// The table walk reads one entry per cycle from the RAM, but for the steps
// in which a merge slots the range in or a remove splits an entry, and
// writes the new table into the other half of the RAM, which becomes current
// when a merge or remove completes without overflowing the table. Done is
// raised in the first cycle in which busy is low again.
// Empty ranges and command 3 skip the walk: done follows in the next cycle.
// A new word may be started in the cycle in which done is shown.
// Reset empties the table at once; the RAM needs no clearing.
`default_nettype none

module interval_set_table_unit
  import ist_pkg::*;
#(
  parameter int MAX_INTERVALS = 16,
  parameter int VALUE_BITS    = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            command,
  input  wire logic [VALUE_BITS-1:0] range_low,
  input  wire logic [VALUE_BITS-1:0] range_high,
  output logic                       done,
  output logic                       covered,
  output logic                       table_full,
  output logic      [COUNT_W-1:0]    interval_count
);

  localparam int IW        = $clog2(MAX_INTERVALS);
  localparam int CW        = $clog2(MAX_INTERVALS + 2);
  localparam int AW        = IW + 1;
  localparam int RAM_DEPTH = 2 ** AW;
  localparam int DW        = 2 * VALUE_BITS;

  state_t                state, state_next;
  cmd_t                  cmd_r, cmd_r_next;
  logic [VALUE_BITS-1:0] lo_r, lo_r_next;
  logic [VALUE_BITS-1:0] hi_r, hi_r_next;
  logic                  bank, bank_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         idx, idx_next;
  logic [CW-1:0]         wr_idx, wr_idx_next;
  logic                  inserted, inserted_next;
  logic                  split, split_next;
  logic [VALUE_BITS-1:0] acc_lo, acc_lo_next;
  logic [VALUE_BITS-1:0] acc_hi, acc_hi_next;
  logic                  acc_valid, acc_valid_next;
  logic                  hit, hit_next;
  logic                  done_next;
  logic                  covered_next;
  logic                  table_full_next;
  logic [COUNT_W-1:0]    interval_count_next;

  logic                  accept;
  logic                  trivial;
  logic                  modifies;
  logic                  overflow;
  logic [CW-1:0]         final_count;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [DW-1:0]         ram_wdata;
  logic [DW-1:0]         ram_rdata;

  step_ctl_t             ctl;
  logic [VALUE_BITS-1:0] emit_lo;
  logic [VALUE_BITS-1:0] emit_hi;
  logic [VALUE_BITS-1:0] acc_lo_new;
  logic [VALUE_BITS-1:0] acc_hi_new;

  ist_ram #(
    .WIDTH (DW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ist_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .cmd        (cmd_r),
    .range_lo   (lo_r),
    .range_hi   (hi_r),
    .ent_lo     (ram_rdata[DW-1:VALUE_BITS]),
    .ent_hi     (ram_rdata[VALUE_BITS-1:0]),
    .ent_valid  (idx < count),
    .inserted   (inserted),
    .split      (split),
    .acc_lo     (acc_lo),
    .acc_hi     (acc_hi),
    .acc_valid  (acc_valid),
    .ctl        (ctl),
    .emit_lo    (emit_lo),
    .emit_hi    (emit_hi),
    .acc_lo_new (acc_lo_new),
    .acc_hi_new (acc_hi_new)
  );

  assign busy     = (state == ST_RUN);
  assign accept   = start && !busy;
  assign trivial  = (cmd_t'(command) == CMD_RSVD) || (range_low > range_high);
  assign modifies = (cmd_r == CMD_MERGE) || (cmd_r == CMD_REMOVE);

  assign final_count = wr_idx + CW'(ctl.emit);
  assign overflow    = final_count > CW'(MAX_INTERVALS);

  assign ram_waddr = {~bank, wr_idx[IW-1:0]};
  assign ram_raddr = {bank, idx_next[IW-1:0]};
  assign ram_wdata = {emit_lo, emit_hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bank  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      bank  <= bank_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_r_next;
    lo_r           <= lo_r_next;
    hi_r           <= hi_r_next;
    idx            <= idx_next;
    wr_idx         <= wr_idx_next;
    inserted       <= inserted_next;
    split          <= split_next;
    acc_lo         <= acc_lo_next;
    acc_hi         <= acc_hi_next;
    acc_valid      <= acc_valid_next;
    hit            <= hit_next;
    covered        <= covered_next;
    table_full     <= table_full_next;
    interval_count <= interval_count_next;
  end

  always_comb begin
    state_next          = state;
    cmd_r_next          = cmd_r;
    lo_r_next           = lo_r;
    hi_r_next           = hi_r;
    bank_next           = bank;
    count_next          = count;
    idx_next            = idx;
    wr_idx_next         = wr_idx;
    inserted_next       = inserted;
    split_next          = split;
    acc_lo_next         = acc_lo;
    acc_hi_next         = acc_hi;
    acc_valid_next      = acc_valid;
    hit_next            = hit;
    done_next           = 1'b0;
    covered_next        = covered;
    table_full_next     = table_full;
    interval_count_next = interval_count;
    ram_we              = 1'b0;

    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (accept) begin
          cmd_r_next     = cmd_t'(command);
          lo_r_next      = range_low;
          hi_r_next      = range_high;
          wr_idx_next    = '0;
          inserted_next  = 1'b0;
          split_next     = 1'b0;
          acc_valid_next = 1'b0;
          hit_next       = 1'b0;
          if (trivial) begin
            done_next           = 1'b1;
            covered_next        = (cmd_t'(command) == CMD_QUERY);
            table_full_next     = 1'b0;
            interval_count_next = COUNT_W'(count);
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (ctl.advance) begin
          idx_next = idx + 1'b1;
        end
        if (ctl.set_inserted) begin
          inserted_next = 1'b1;
        end
        split_next = ctl.split_next;
        if (ctl.acc_upd) begin
          acc_lo_next    = acc_lo_new;
          acc_hi_next    = acc_hi_new;
          acc_valid_next = 1'b1;
        end
        if (ctl.hit) begin
          hit_next = 1'b1;
        end
        if (ctl.emit) begin
          ram_we      = wr_idx < CW'(MAX_INTERVALS);
          wr_idx_next = wr_idx + 1'b1;
        end
        if (ctl.finish) begin
          state_next      = ST_IDLE;
          done_next       = 1'b1;
          covered_next    = (cmd_r == CMD_QUERY) && hit;
          table_full_next = modifies && overflow;
          if (modifies && !overflow) begin
            bank_next           = ~bank;
            count_next          = final_count;
            interval_count_next = COUNT_W'(final_count);
          end else begin
            interval_count_next = COUNT_W'(count);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/ist_checker.sv @@
// Port-level checks for interval_set_table_unit, with its bind statement.
// Depends on ist_pkg and interval_set_table_unit_defines.svh.
`default_nettype none

`include "interval_set_table_unit_defines.svh"

module ist_checker
  import ist_pkg::*;
#(
  parameter int MAX_INTERVALS = 16,
  parameter int VALUE_BITS    = 32
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [1:0]            command,
  input wire logic [VALUE_BITS-1:0] range_low,
  input wire logic [VALUE_BITS-1:0] range_high,
  input wire logic                  done,
  input wire logic                  covered,
  input wire logic                  table_full,
  input wire logic [COUNT_W-1:0]    interval_count
);

  logic trivial_word;

  assign trivial_word = (command == CMD_RSVD) || (range_low > range_high);

  // an accepted word either starts a walk or answers at once
  `IST_ASSERT_NXT(a_accept_follow, start && !busy, busy || done)

  // reserved commands and empty ranges skip the walk
  `IST_ASSERT_NXT(a_trivial, start && !busy && trivial_word, done && !busy)

  // a result only ever follows a walk or an accepted word
  `IST_ASSERT_IMP(a_done_origin, done, $past(busy) || $past(start))

  // a dropped operation found the table full
  `IST_ASSERT_IMP(a_full_count, done && table_full, interval_count == COUNT_W'(MAX_INTERVALS))

  // only a query reports cover, and a query never needs a slot
  `IST_ASSERT_IMP(a_excl, done, !(covered && table_full))

endmodule

bind interval_set_table_unit ist_checker #(
  .MAX_INTERVALS (MAX_INTERVALS),
  .VALUE_BITS    (VALUE_BITS)
) u_ist_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .command        (command),
  .range_low      (range_low),
  .range_high     (range_high),
  .done           (done),
  .covered        (covered),
  .table_full     (table_full),
  .interval_count (interval_count)
);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking bench for interval_set_table_unit: merge, remove and query words.
// Depends on ist_pkg and the interval_set_table_unit RTL; a local table model
// predicts every result word.
`timescale 1ns / 100ps

module tb;
  import ist_pkg::*;

  localparam int DEPTH     = 16;
  localparam int VBITS     = 32;
  localparam int LIMIT     = 400000;
  localparam int TAIL      = 2 * DEPTH + 8;
  localparam int N_RANDOM  = 1400;

  typedef logic [VBITS-1:0] val_t;

  typedef struct {
    cmd_t op;
    val_t lo;
    val_t hi;
    bit   hold;
  } word_t;

  typedef struct packed {
    logic               covered;
    logic               full;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  cmd_t               command = CMD_MERGE;
  val_t               range_low = '0;
  val_t               range_high = '0;
  logic               busy;
  logic               done;
  logic               covered;
  logic               table_full;
  logic [COUNT_W-1:0] interval_count;

  word_t    word_q[$];
  outcome_t expected_outcome [0:4095];
  int       n_taken = 0;
  int       n_seen = 0;
  int       n_total = 0;
  int       errors = 0;
  int       cycles = 0;

  val_t lo_tab [0:DEPTH-1];
  val_t hi_tab [0:DEPTH-1];
  int   n_held = 0;

  interval_set_table_unit #(
    .MAX_INTERVALS(DEPTH),
    .VALUE_BITS   (VBITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .range_low     (range_low),
    .range_high    (range_high),
    .done          (done),
    .covered       (covered),
    .table_full    (table_full),
    .interval_count(interval_count)
  );

  always #1 clk = ~clk;

  // b lies more than one above a, no wrap
  function automatic bit spaced(val_t a, val_t b);
    return b > a && (b - a) > 1;
  endfunction

  function automatic void open_entry(int pos);
    for (int k = n_held; k > pos; k--) begin
      lo_tab[k] = lo_tab[k-1];
      hi_tab[k] = hi_tab[k-1];
    end
    n_held++;
  endfunction

  function automatic void close_entries(int first, int last);
    int d;
    d = last - first;
    for (int k = last; k < n_held; k++) begin
      lo_tab[k-d] = lo_tab[k];
      hi_tab[k-d] = hi_tab[k];
    end
    n_held -= d;
  endfunction

  function automatic bit fuse_range(val_t lo, val_t hi);
    int n;
    int i;
    int j;
    n = n_held;
    i = 0;
    while (i < n && spaced(hi_tab[i], lo)) i++;
    if (i == n || spaced(hi, lo_tab[i])) begin
      if (n >= DEPTH) return 1'b1;
      open_entry(i);
      lo_tab[i] = lo;
      hi_tab[i] = hi;
      return 1'b0;
    end
    if (lo_tab[i] <= lo && hi <= hi_tab[i]) return 1'b0;
    if (lo < lo_tab[i]) lo_tab[i] = lo;
    if (hi_tab[i] < hi) begin
      hi_tab[i] = hi;
      j = i + 1;
      while (j < n && !spaced(hi_tab[i], lo_tab[j])) begin
        if (hi_tab[i] < hi_tab[j]) hi_tab[i] = hi_tab[j];
        j++;
      end
      close_entries(i + 1, j);
    end
    return 1'b0;
  endfunction

  function automatic bit cut_range(val_t lo, val_t hi);
    int i;
    i = 0;
    while (i < n_held && hi_tab[i] < lo) i++;
    while (i < n_held) begin
      if (hi < lo_tab[i]) return 1'b0;
      if (lo_tab[i] < lo) begin
        if (hi < hi_tab[i]) begin
          if (n_held >= DEPTH) return 1'b1;
          open_entry(i);
          hi_tab[i]   = lo - 1;
          lo_tab[i+1] = hi + 1;
          return 1'b0;
        end
        hi_tab[i] = lo - 1;
        i++;
      end else if (hi < hi_tab[i]) begin
        lo_tab[i] = hi + 1;
        return 1'b0;
      end else begin
        close_entries(i, i + 1);
      end
    end
    return 1'b0;
  endfunction

  function automatic bit holds_range(val_t lo, val_t hi);
    int i;
    i = 0;
    while (i < n_held && lo > hi_tab[i]) i++;
    if (i == n_held) return 1'b0;
    return lo >= lo_tab[i] && hi <= hi_tab[i];
  endfunction

  function automatic outcome_t run_table_op(cmd_t op, val_t lo, val_t hi);
    outcome_t r;
    r = '0;
    case (op)
      CMD_QUERY:  r.covered = (lo > hi) ? 1'b1 : holds_range(lo, hi);
      CMD_MERGE:  if (lo <= hi) r.full = fuse_range(lo, hi);
      CMD_REMOVE: if (lo <= hi) r.full = cut_range(lo, hi);
      default:    ;
    endcase
    r.count = n_held[COUNT_W-1:0];
    return r;
  endfunction

  task automatic add_word(cmd_t op, val_t lo, val_t hi, bit hold = 1'b0);
    word_t w;
    w.op   = op;
    w.lo   = lo;
    w.hi   = hi;
    w.hold = hold;
    word_q.push_back(w);
  endtask

  function automatic val_t pick_point(int zone);
    case (zone)
      0:       return val_t'($urandom_range(0, 255));
      1:       return 32'hFFFF_FF00 + val_t'($urandom_range(0, 255));
      default: return val_t'($urandom());
    endcase
  endfunction

  function automatic int pick_zone();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 87) return 1;
    return 2;
  endfunction

  function automatic val_t end_of(val_t lo, int w);
    logic [VBITS:0] s;
    s = {1'b0, lo} + w;
    return s[VBITS] ? '1 : s[VBITS-1:0];
  endfunction

  task automatic add_random_word(bit hold);
    int   zone;
    int   r;
    cmd_t op;
    val_t lo;
    val_t hi;
    val_t t;
    zone = pick_zone();
    r = $urandom_range(0, 99);
    if (r < 42) op = CMD_MERGE;
    else if (r < 72) op = CMD_REMOVE;
    else if (r < 96) op = CMD_QUERY;
    else op = CMD_RSVD;
    lo = pick_point(zone);
    if (zone == 2 && $urandom_range(0, 1)) begin
      hi = val_t'($urandom());
      if (hi < lo) begin
        t = lo; lo = hi; hi = t;
      end
    end else if ($urandom_range(0, 9) == 0) begin
      hi = end_of(lo, $urandom_range(0, 80));
    end else begin
      hi = end_of(lo, $urandom_range(0, 12));
    end
    if ($urandom_range(0, 19) == 0 && lo != hi) begin
      t = lo; lo = hi; hi = t;
    end
    add_word(op, lo, hi, hold);
  endtask

  // may clear the whole table, packs it past full with spaced intervals, then removes and queries
  task automatic add_fill_burst();
    int   zone;
    val_t base;
    zone = ($urandom_range(0, 3) == 0) ? 1 : 0;
    base = (zone == 1) ? 32'hFFFF_FF00 + val_t'($urandom_range(0, 100))
                       : val_t'($urandom_range(0, 150));
    if ($urandom_range(0, 1)) add_word(CMD_REMOVE, '0, '1);
    for (int k = 0; k < DEPTH + 1; k++)
      add_word(CMD_MERGE, base + 4 * k, base + 4 * k + $urandom_range(0, 2));
    add_word(CMD_REMOVE, base + 4 * $urandom_range(0, 15) + 1,
             base + 4 * $urandom_range(0, 15) + 1);
    add_word(CMD_QUERY, base + $urandom_range(0, 40), base + $urandom_range(0, 70));
  endtask

  initial begin
    add_word(CMD_QUERY, 0, 0);
    add_word(CMD_QUERY, 5, 3);
    add_word(CMD_MERGE, 9, 4);
    add_word(CMD_REMOVE, 9, 4);
    add_word(CMD_RSVD, '1, '1);
    add_word(CMD_MERGE, 0, 0);
    add_word(CMD_MERGE, 2, 2);
    add_word(CMD_MERGE, 1, 1);
    add_word(CMD_MERGE, '1, '1);
    add_word(CMD_QUERY, 0, 2);
    add_word(CMD_QUERY, 0, 3);
    add_word(CMD_REMOVE, 1, 1);
    add_word(CMD_MERGE, 0, '1);
    add_word(CMD_QUERY, 0, '1);
    add_word(CMD_REMOVE, 0, '1);
    for (int k = 0; k < DEPTH; k++)
      add_word(CMD_MERGE, 4 * k, 4 * k + 2, k == 0);
    add_word(CMD_MERGE, 100, 100);
    add_word(CMD_REMOVE, 5, 5);
    add_word(CMD_MERGE, 3, 3);
    add_word(CMD_REMOVE, 2, 9);
    add_random_word(1'b1);
    while (word_q.size() < N_RANDOM + 35) begin
      if ($urandom_range(0, 99) < 6) add_fill_burst();
      else add_random_word($urandom_range(0, 99) < 2);
    end
    n_total = word_q.size();
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  always @(posedge clk) begin : drive
    bit       took;
    int       taken_now;
    int       idle_pct;
    word_t    w;
    outcome_t o;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = 1'b0;
      if (start && !busy) begin
        o = run_table_op(command, range_low, range_high);
        expected_outcome[n_taken] = o;
        took = 1'b1;
      end
      taken_now = n_taken + took;
      n_taken <= taken_now;
      if (!start || took) begin
        if (taken_now < n_total / 3) idle_pct = 37;
        else if (taken_now < 2 * n_total / 3) idle_pct = 58;
        else idle_pct = 0;
        if (word_q.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
            (!word_q[0].hold || n_seen == taken_now)) begin
          w = word_q.pop_front();
          command    <= w.op;
          range_low  <= w.lo;
          range_high <= w.hi;
          start      <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    outcome_t e;
    if (!rst && done) begin
      if (n_seen >= n_taken) begin
        $error("result word with none expected");
        errors++;
      end else begin
        e = expected_outcome[n_seen];
        if (covered !== e.covered) begin
          $error("covered: expected %0b, got %0b", e.covered, covered);
          errors++;
        end
        if (table_full !== e.full) begin
          $error("table_full: expected %0b, got %0b", e.full, table_full);
          errors++;
        end
        if (interval_count !== e.count) begin
          $error("interval_count: expected %0d, got %0d", e.count, interval_count);
          errors++;
        end
        n_seen <= n_seen + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    do @(negedge clk);
    while (rst || n_total == 0 || word_q.size() > 0 || start || n_seen != n_taken);
    repeat (TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
